// ===== hdl/fla_pkg.sv =====
package fla_pkg;

  // request codes
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  // result codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_MEM   = 2'd1,
    STAT_PACK     = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [9:0]  size_bytes;
    logic [3:0]  start_block;
  } fla_in_t;

  typedef struct packed {
    logic [3:0]  alloc_block;
    status_e     status;
    logic [4:0]  free_count;
  } fla_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_DECIDE,
    ST_FREE_WR,
    ST_SRCH,
    ST_RUN_RD,
    ST_RUN_EV,
    ST_SORT_RD,
    ST_SORT_EV,
    ST_ASC_RD,
    ST_ASC_EV,
    ST_ASC_END,
    ST_DONE
  } fla_state_e;

endpackage

// ===== hdl/free_list_block_allocator.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o | in_item_i  (action, size, start block)
// out     | output    | out_valid_o / out_ready_i | out_item_o (block, status, free count)
//
// one item at a time; the block count comes from a registered reciprocal multiply
// free: one table write per freed block; alloc: a read state and an evaluate state per list entry walked,
// and a failed first walk adds a sort (mark the entries, then relink them in ascending order) and a second walk
// after reset a fill pass writes the table before the first item
// the output register lets the next item be taken while a result waits
module free_list_block_allocator
  import fla_pkg::*;
#(
  parameter int NUM_BLOCKS  = 16,
  parameter int BLOCK_BYTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fla_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fla_out_t out_item_o
);

  logic     res_valid, res_ready;
  fla_out_t res_item;
  logic     out_valid_q;
  fla_out_t out_item_q;

  fla_ctrl #(.NUM_BLOCKS(NUM_BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a failed request never reports a block; a free request reports none either, but only failures are checked
  a_fail_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_item.status != STAT_OK) |-> res_item.alloc_block == 4'd0)
    else $error("failed request reports a block");

  // a finished result is held until the output register takes it
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
    else $error("result dropped before hand-over");

  // no item is taken while a result is still inside the sequencer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !res_valid)
    else $error("item taken while result pending");

endmodule

// ===== hdl/fla_ram.sv =====
module fla_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fla_div.sv =====
module fla_div #(
  parameter int BLOCK_BYTES = 8,
  parameter int NW          = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [9:0]    size_i,
  output logic          done_o,
  output logic [NW-1:0] count_o
);

  localparam int LB = $clog2(BLOCK_BYTES);
  localparam int SH = NW + LB;
  localparam int PW = 2 * NW + 1;
  // rounded-up reciprocal, exact for every numerator below 2**NW
  localparam logic [NW:0] RECIP = (NW + 1)'(((1 << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES);

  logic [NW-1:0] num;
  logic [PW-1:0] prod;
  logic [NW-1:0] quo_q;
  logic          done_q;

  // rounded-up block count by reciprocal multiplication
  assign num  = NW'(size_i) + NW'(BLOCK_BYTES - 1);
  assign prod = PW'(num) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= NW'(prod >> SH);
    end
  end

  // a size of zero still takes one block
  assign done_o  = done_q;
  assign count_o = (quo_q == '0) ? NW'(1) : quo_q;

endmodule

// ===== hdl/fla_ctrl.sv =====
module fla_ctrl
  import fla_pkg::*;
#(
  parameter int NUM_BLOCKS  = 16,
  parameter int BLOCK_BYTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fla_in_t  in_item_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output fla_out_t res_item_o
);

  localparam int IW = $clog2(NUM_BLOCKS + 1);
  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int NW = $clog2(1024 + BLOCK_BYTES);
  localparam int SW = ((IW > NW) ? IW : NW) + 1;
  localparam int VW = IW + 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(NUM_BLOCKS);

  fla_state_e state_q, state_d;

  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] free_q, free_d;
  logic [NW-1:0] cnt_q, cnt_d;
  action_e       action_q, action_d;
  logic [3:0]    start_q, start_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] run_q, run_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [IW-1:0] len_q, len_d;
  logic [VW-1:0] vis_q, vis_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] steps_q, steps_d;
  logic          second_q, second_d;
  logic [IW-1:0] grant_q, grant_d;
  status_e       status_q, status_d;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [IW-1:0] tbl_wdata, tbl_rdata;
  logic          mk_we, mk_wdata, mk_rdata;
  logic [AW-1:0] mk_waddr, mk_raddr;

  logic          div_start, div_done;
  logic [NW-1:0] div_count;

  logic [IW-1:0] nx;
  logic [VW-1:0] vis_sum;
  logic [SW-1:0] free_sum, free_end;

  function automatic logic [IW-1:0] norm(input logic [IW-1:0] v);
    return (v >= NULL_IDX) ? NULL_IDX : v;
  endfunction

  // next-pointer table and sort marks
  fla_ram #(.WIDTH(IW), .DEPTH(NUM_BLOCKS)) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  fla_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_mark (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .raddr_i (mk_raddr),
    .rdata_o (mk_rdata)
  );

  fla_div #(.BLOCK_BYTES(BLOCK_BYTES), .NW(NW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .size_i  (in_item_i.size_bytes),
    .done_o  (div_done),
    .count_o (div_count)
  );

  assign nx       = norm(tbl_rdata);
  assign vis_sum  = vis_q + VW'(len_q);
  assign free_sum = SW'(free_q) + SW'(cnt_q);
  assign free_end = SW'(start_q) + SW'(cnt_q);

  // sequencer: next state, memory accesses, bookkeeping
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    free_d   = free_q;
    cnt_d    = cnt_q;
    action_d = action_q;
    start_d  = start_q;
    ptr_d    = ptr_q;
    run_d    = run_q;
    prev_d   = prev_q;
    len_d    = len_q;
    vis_d    = vis_q;
    tail_d   = tail_q;
    steps_d  = steps_q;
    second_d = second_q;
    grant_d  = grant_q;
    status_d = status_q;

    tbl_we    = 1'b0;
    tbl_waddr = AW'(ptr_q);
    tbl_wdata = ptr_q + IW'(1);
    tbl_raddr = AW'(ptr_q);
    mk_we     = 1'b0;
    mk_waddr  = AW'(ptr_q);
    mk_wdata  = 1'b0;
    mk_raddr  = AW'(ptr_q);

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      // fill the table with the ascending chain after reset
      ST_INIT: begin
        tbl_we = 1'b1;
        mk_we  = 1'b1;
        ptr_d  = ptr_q + IW'(1);
        if (ptr_q == IW'(NUM_BLOCKS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          div_start = 1'b1;
          action_d  = in_item_i.action;
          start_d   = in_item_i.start_block;
          grant_d   = '0;
          status_d  = STAT_OK;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          cnt_d   = div_count;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        ptr_d    = '0;
        second_d = 1'b0;
        if (action_q == ACT_FREE) begin
          if (free_end > SW'(NUM_BLOCKS)) begin
            status_d = STAT_RANGE;
            state_d  = ST_DONE;
          end else begin
            state_d = ST_FREE_WR;
          end
        end else if (SW'(free_q) < SW'(cnt_q)) begin
          status_d = STAT_NO_MEM;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_SRCH;
        end
      end

      // link the freed run in order, last entry to the old head
      ST_FREE_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = AW'(SW'(start_q) + SW'(ptr_q));
        if (SW'(ptr_q) + SW'(1) < SW'(cnt_q)) begin
          tbl_wdata = IW'(SW'(start_q) + SW'(ptr_q) + SW'(1));
          ptr_d     = ptr_q + IW'(1);
        end else begin
          tbl_wdata = norm(head_q);
          head_d    = IW'(start_q);
          free_d    = (free_sum > SW'(NUM_BLOCKS)) ? NULL_IDX : IW'(free_sum);
          state_d   = ST_DONE;
        end
      end

      // start a first-fit walk from the head
      ST_SRCH: begin
        prev_d = NULL_IDX;
        vis_d  = '0;
        len_d  = IW'(1);
        ptr_d  = head_q;
        run_d  = head_q;
        if (norm(head_q) == NULL_IDX) begin
          if (second_q) begin
            status_d = STAT_PACK;
            state_d  = ST_DONE;
          end else begin
            second_d = 1'b1;
          end
        end else begin
          state_d = ST_RUN_RD;
        end
      end

      ST_RUN_RD: begin
        state_d = ST_RUN_EV;
      end

      ST_RUN_EV: begin
        if (SW'(len_q) >= SW'(cnt_q)) begin
          // run long enough: unlink the granted blocks
          if (prev_q == NULL_IDX) begin
            head_d = nx;
          end else begin
            tbl_we    = 1'b1;
            tbl_waddr = AW'(prev_q);
            tbl_wdata = nx;
          end
          free_d  = free_q - IW'(cnt_q);
          grant_d = run_q;
          state_d = ST_DONE;
        end else if (nx != NULL_IDX && nx == ptr_q + IW'(1) && len_q < NULL_IDX) begin
          len_d   = len_q + IW'(1);
          ptr_d   = nx;
          state_d = ST_RUN_RD;
        end else if (nx == NULL_IDX || vis_sum >= VW'(NUM_BLOCKS)) begin
          // walk exhausted
          if (second_q) begin
            status_d = STAT_PACK;
            state_d  = ST_DONE;
          end else if (head_q >= NULL_IDX) begin
            second_d = 1'b1;
            state_d  = ST_SRCH;
          end else begin
            ptr_d   = head_q;
            steps_d = '0;
            state_d = ST_SORT_RD;
          end
        end else begin
          vis_d   = vis_sum;
          prev_d  = ptr_q;
          run_d   = nx;
          ptr_d   = nx;
          len_d   = IW'(1);
          state_d = ST_RUN_RD;
        end
      end

      // sort: mark every entry reached from the head
      ST_SORT_RD: begin
        mk_we    = 1'b1;
        mk_wdata = 1'b1;
        state_d  = ST_SORT_EV;
      end

      ST_SORT_EV: begin
        steps_d = steps_q + IW'(1);
        if (nx < NULL_IDX && steps_q + IW'(1) < NULL_IDX) begin
          ptr_d   = nx;
          state_d = ST_SORT_RD;
        end else begin
          ptr_d   = '0;
          tail_d  = NULL_IDX;
          head_d  = NULL_IDX;
          state_d = ST_ASC_RD;
        end
      end

      // sort: relink marked entries in ascending order, clearing marks
      ST_ASC_RD: begin
        state_d = ST_ASC_EV;
      end

      ST_ASC_EV: begin
        if (mk_rdata) begin
          mk_we = 1'b1;
          if (tail_q == NULL_IDX) begin
            head_d = ptr_q;
          end else begin
            tbl_we    = 1'b1;
            tbl_waddr = AW'(tail_q);
            tbl_wdata = ptr_q;
          end
          tail_d = ptr_q;
        end
        if (ptr_q == IW'(NUM_BLOCKS - 1)) begin
          state_d = ST_ASC_END;
        end else begin
          ptr_d   = ptr_q + IW'(1);
          state_d = ST_ASC_RD;
        end
      end

      ST_ASC_END: begin
        if (tail_q != NULL_IDX) begin
          tbl_we    = 1'b1;
          tbl_waddr = AW'(tail_q);
          tbl_wdata = NULL_IDX;
        end
        second_d = 1'b1;
        state_d  = ST_SRCH;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      ptr_q    <= '0;
      head_q   <= '0;
      free_q   <= NULL_IDX;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      head_q   <= head_d;
      free_q   <= free_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    action_q <= action_d;
    start_q  <= start_d;
    run_q    <= run_d;
    prev_q   <= prev_d;
    len_q    <= len_d;
    vis_q    <= vis_d;
    tail_q   <= tail_d;
    steps_q  <= steps_d;
    grant_q  <= grant_d;
    status_q <= status_d;
  end

  assign res_item_o.alloc_block = 4'(grant_q);
  assign res_item_o.status      = status_q;
  assign res_item_o.free_count  = 5'(free_q);

endmodule
